// ===== hdl/vn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalizer
// Field widths, fixed-point format and the structs that carry transfers.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COMP_W    = 24;
  localparam int UNIT_W    = FRAC_BITS + 2;
  localparam int MAG_W     = 24;
  localparam int TOL_W     = 16;
  localparam int SUM_W     = 2 * COMP_W;
  localparam int REM_W     = MAG_W + 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DREM_W    = MAG_W + 1;
  localparam int NUM_COMP  = 3;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [MAG_W-1:0]         magnitude;
    logic                     zero_vector;
    logic                     was_unit;
  } vn_out_t;

  typedef struct packed {
    logic [NUM_COMP-1:0][COMP_W-1:0] a;
    logic [NUM_COMP-1:0]             neg;
  } vn_side_t;

  typedef struct packed {
    logic en;
    logic vld;
  } vn_ctl_t;

endpackage

// ===== hdl/vn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One root bit is settled per stage; the component data rides along.
// ----------------------------------------------------------------------------
module vn_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vn_pkg::vn_ctl_t          in_ctl,
  input  logic [vn_pkg::SUM_W-1:0] in_sum,
  input  vn_pkg::vn_side_t         in_side,
  output logic                     out_valid,
  output logic [vn_pkg::MAG_W-1:0] out_root,
  output vn_pkg::vn_side_t         out_side
);
  import vn_pkg::*;

  logic [SUM_W-1:0] rad_r  [MAG_W];
  logic [REM_W-1:0] rem_r  [MAG_W];
  logic [MAG_W-1:0] root_r [MAG_W];
  vn_side_t         side_r [MAG_W];
  logic [MAG_W-1:0] vld_r;

  for (genvar s = 0; s < MAG_W; s++) begin : g_stage
    logic [SUM_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in;
    logic [MAG_W-1:0] root_in;
    vn_side_t         side_in;
    logic             vld_in;
    logic [REM_W+1:0] rr;
    logic [REM_W+1:0] tr;
    logic [REM_W+1:0] diff;
    logic [SUM_W-1:0] rad_nxt;
    logic [REM_W-1:0] rem_nxt;
    logic [MAG_W-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign rad_in  = in_sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_ctl.vld;
    end else begin : g_next
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    assign rr   = {rem_in, rad_in[SUM_W-1 -: 2]};
    assign tr   = {2'b00, root_in, 2'b01};
    assign diff = rr - tr;

    always_comb begin
      rad_nxt = {rad_in[SUM_W-3:0], 2'b00};
      if (rr >= tr) begin
        rem_nxt  = diff[REM_W-1:0];
        root_nxt = {root_in[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rr[REM_W-1:0];
        root_nxt = {root_in[MAG_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (in_ctl.en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (in_ctl.en) begin
        rad_r[s]  <= rad_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[MAG_W-1];
  assign out_root  = root_r[MAG_W-1];
  assign out_side  = side_r[MAG_W-1];

endmodule

// ===== hdl/vn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div: pipelined three-lane restoring divider
// Divides each scaled component magnitude by the norm, one quotient bit
// per stage in every lane.
// ----------------------------------------------------------------------------
module vn_div (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  vn_pkg::vn_ctl_t                              in_ctl,
  input  logic [vn_pkg::MAG_W-1:0]                     in_mag,
  input  vn_pkg::vn_side_t                             in_side,
  output logic                                         out_valid,
  output logic [vn_pkg::NUM_COMP-1:0][vn_pkg::QUO_W-1:0] out_quo,
  output logic [vn_pkg::MAG_W-1:0]                     out_mag,
  output logic [vn_pkg::NUM_COMP-1:0]                  out_neg
);
  import vn_pkg::*;

  logic [NUM_COMP-1:0][DREM_W-1:0] rem_r [QUO_W];
  logic [NUM_COMP-1:0][QUO_W-1:0]  quo_r [QUO_W];
  logic [MAG_W-1:0]                mag_r [QUO_W];
  logic [NUM_COMP-1:0]             neg_r [QUO_W];
  logic [QUO_W-1:0]                vld_r;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_COMP-1:0][DREM_W-1:0] rem_in;
    logic [NUM_COMP-1:0][QUO_W-1:0]  quo_in;
    logic [MAG_W-1:0]                mag_in;
    logic [NUM_COMP-1:0]             neg_in;
    logic                            vld_in;
    logic [NUM_COMP-1:0][DREM_W-1:0] rem_nxt;
    logic [NUM_COMP-1:0][QUO_W-1:0]  quo_nxt;
    logic [DREM_W-1:0]               sub;

    if (s == 0) begin : g_first
      for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        assign rem_in[c] = {1'b0, in_side.a[c]};
        assign quo_in[c] = '0;
      end
      assign mag_in = in_mag;
      assign neg_in = in_side.neg;
      assign vld_in = in_ctl.vld;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign mag_in = mag_r[s-1];
      assign neg_in = neg_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      sub = '0;
      for (int c = 0; c < NUM_COMP; c++) begin
        if (rem_in[c] >= {1'b0, mag_in}) begin
          sub        = rem_in[c] - {1'b0, mag_in};
          quo_nxt[c] = {quo_in[c][QUO_W-2:0], 1'b1};
        end else begin
          sub        = rem_in[c];
          quo_nxt[c] = {quo_in[c][QUO_W-2:0], 1'b0};
        end
        rem_nxt[c] = {sub[DREM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (in_ctl.en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (in_ctl.en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        mag_r[s] <= mag_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_mag   = mag_r[QUO_W-1];
  assign out_neg   = neg_r[QUO_W-1];

endmodule

// ===== hdl/vector3_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize: fixed-point 3D vector normalizer
// Gives the norm of a Q8.16 vector and the vector scaled to unit length.
//
//   channel  ports                          transfer
//   in       in_valid in_ready in_data      one vector per transfer
//   out      out_valid out_ready out_data   one result per vector
//   cfg      psel penable pwrite paddr ...  unit_tolerance at address 0
//
// One vector is accepted every cycle while no result is held at the output.
// Data passes the abs, square and sum registers, 24 square-root stages, 17
// divider stages and the output register. Reset clears all valid bits and the tolerance.
// When out_ready is low with a result waiting, the whole pipeline holds.
// ----------------------------------------------------------------------------
module vector3_normalize (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  vn_pkg::vn_in_t           in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output vn_pkg::vn_out_t          out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import vn_pkg::*;

  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;

  logic             en;
  logic [TOL_W-1:0] tol_r;

  logic             va_r;
  vn_side_t         sa_r;
  vn_side_t         sa_nxt;
  logic             vb_r;
  vn_side_t         sb_r;
  logic [NUM_COMP-1:0][SUM_W-1:0] sq_r;
  logic             vc_r;
  vn_side_t         sc_r;
  logic [SUM_W-1:0] sum_r;
  logic [COMP_W-1:0] comp [NUM_COMP];

  vn_ctl_t          sq_ctl;
  vn_ctl_t          dv_ctl;
  logic             sq_valid;
  logic [MAG_W-1:0] sq_root;
  vn_side_t         sq_side;
  logic             dv_valid;
  logic [NUM_COMP-1:0][QUO_W-1:0] dv_quo;
  logic [MAG_W-1:0] dv_mag;
  logic [NUM_COMP-1:0] dv_neg;

  logic             out_valid_r;
  vn_out_t          out_data_r;
  vn_out_t          out_nxt;
  logic [NUM_COMP-1:0][UNIT_W-1:0] unit;
  logic [MAG_W-1:0] mag_dist;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (!paddr[2]) ? {{(32-TOL_W){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  // Absolute values, squares and their sum.
  assign comp[0] = in_data.comp_x;
  assign comp[1] = in_data.comp_y;
  assign comp[2] = in_data.comp_z;

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      sa_nxt.neg[c] = comp[c][COMP_W-1];
      sa_nxt.a[c]   = comp[c][COMP_W-1] ? (COMP_W'(0) - comp[c]) : comp[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r  <= sa_nxt;
      sb_r  <= sa_r;
      for (int c = 0; c < NUM_COMP; c++) begin
        sq_r[c] <= SUM_W'(sa_r.a[c]) * SUM_W'(sa_r.a[c]);
      end
      sc_r  <= sb_r;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign sq_ctl = '{en: en, vld: vc_r};

  vn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (sq_ctl),
    .in_sum    (sum_r),
    .in_side   (sc_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign dv_ctl = '{en: en, vld: sq_valid};

  vn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (dv_ctl),
    .in_mag    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_mag   (dv_mag),
    .out_neg   (dv_neg)
  );

  // Sign, zero handling and the unit flag.
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      if (dv_mag == '0) begin
        unit[c] = '0;
      end else if (dv_neg[c]) begin
        unit[c] = UNIT_W'(0) - {1'b0, dv_quo[c]};
      end else begin
        unit[c] = {1'b0, dv_quo[c]};
      end
    end
    mag_dist = (dv_mag >= ONE) ? (dv_mag - ONE) : (ONE - dv_mag);
    out_nxt.unit_x      = unit[0];
    out_nxt.unit_y      = unit[1];
    out_nxt.unit_z      = unit[2];
    out_nxt.magnitude   = dv_mag;
    out_nxt.zero_vector = (dv_mag == '0);
    out_nxt.was_unit    = (mag_dist <= {{(MAG_W-TOL_W){1'b0}}, tol_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_vector |->
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
    else $error("Zero vector gave nonzero unit components.");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.zero_vector == (out_data.magnitude == '0))
    else $error("Zero flag disagrees with the magnitude.");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.unit_x <= $signed(UNIT_W'(ONE))
      && out_data.unit_x >= -$signed(UNIT_W'(ONE)))
    else $error("Unit component out of range.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Pipeline advanced while the output was stalled.");
`endif

endmodule

// ===== dv/vector3_normalize_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_test: self-checking bench for the vector normalizer
// A queue-fed driver offers vectors with random gaps. A monitor compares each
// result with a predicted norm, unit vector and flags. The tolerance register
// is reprogrammed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module vector3_normalize_test;
  import vn_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  vn_in_t in_data;
  logic out_valid;
  logic out_ready;
  vn_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_TOLERANCE = 3'd0;
  localparam int LATENCY = 45;

  vn_in_t pending_vecs[$];
  vn_out_t expected_results[$];
  logic [TOL_W-1:0] tolerance;
  int mismatches;
  int in_gap;
  int out_gap;
  int hold_cycles;
  bit hold_request;
  bit send_pause;

  vector3_normalize u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitpos;
    root = 0;
    bitpos = 64'd1 << 46;
    while (bitpos > n) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n = n - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic vn_out_t normalize_vec(vn_in_t v);
    vn_out_t r;
    logic [63:0] mag_abs[3];
    logic neg[3];
    logic [63:0] sum;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] dist_one;
    logic [63:0] one;
    logic signed [COMP_W-1:0] c[3];
    logic [UNIT_W-1:0] u[3];
    c[0] = v.comp_x;
    c[1] = v.comp_y;
    c[2] = v.comp_z;
    sum = 0;
    one = 64'd1 << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][COMP_W-1];
      mag_abs[i] = neg[i] ? (64'd1 << COMP_W) - {40'd0, c[i]} : {40'd0, c[i]};
      sum = sum + mag_abs[i] * mag_abs[i];
    end
    mag = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      quo = (mag != 0) ? (mag_abs[i] << FRAC_BITS) / mag : 64'd0;
      if (neg[i]) quo = 64'd0 - quo;
      u[i] = quo[UNIT_W-1:0];
    end
    dist_one = (mag >= one) ? mag - one : one - mag;
    r.unit_x = u[0];
    r.unit_y = u[1];
    r.unit_z = u[2];
    r.magnitude = mag[MAG_W-1:0];
    r.zero_vector = (mag == 0);
    r.was_unit = (dist_one <= {48'd0, tolerance});
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    mismatches++;
  endtask

  // Driver: predictions are made at acceptance with the current tolerance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= $urandom_range(0, 12);
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(normalize_vec(in_data));
        void'(pending_vecs.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_vecs.size() > 0 && !send_pause) begin
        in_valid <= 1'b1;
        in_data <= pending_vecs[0];
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor with random back-pressure and an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", 32'd0, 32'd0);
        end else begin
          vn_out_t w;
          w = expected_results.pop_front();
          if (out_data.unit_x !== w.unit_x)
            report_mismatch("unit_x", 32'(out_data.unit_x), 32'(w.unit_x));
          if (out_data.unit_y !== w.unit_y)
            report_mismatch("unit_y", 32'(out_data.unit_y), 32'(w.unit_y));
          if (out_data.unit_z !== w.unit_z)
            report_mismatch("unit_z", 32'(out_data.unit_z), 32'(w.unit_z));
          if (out_data.magnitude !== w.magnitude)
            report_mismatch("magnitude", 32'(out_data.magnitude), 32'(w.magnitude));
          if (out_data.zero_vector !== w.zero_vector)
            report_mismatch("zero_vector", 32'(out_data.zero_vector), 32'(w.zero_vector));
          if (out_data.was_unit !== w.was_unit)
            report_mismatch("was_unit", 32'(out_data.was_unit), 32'(w.was_unit));
        end
      end
      if (hold_request && hold_cycles == 0) begin
        hold_cycles <= 300;
        out_ready <= 1'b0;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
      end else if (hold_cycles == 1) begin
        hold_cycles <= 0;
        out_ready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_TOLERANCE;
    pwdata <= {16'($urandom_range(0, 65535)), 16'd0} | {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tolerance = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending_vecs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return COMP_W'($urandom_range(0, 255) - 128);
      1: return COMP_W'(($urandom_range(0, 1) ? 24'h010000 : 24'hff0000)
                        + $urandom_range(0, 7) - 3);
      2: return COMP_W'($urandom_range(0, 65535) - 32768);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic push_vec(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y, logic [COMP_W-1:0] z);
    vn_in_t v;
    v.comp_x = x;
    v.comp_y = y;
    v.comp_z = z;
    pending_vecs.push_back(v);
  endtask

  initial begin
    logic [TOL_W-1:0] tol_set[5];
    tol_set = '{16'd0, 16'hffff, 16'd4, 16'd300, 16'd0};
    mismatches = 0;
    tolerance = 0;
    hold_request = 0;
    send_pause = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: zero vector, unit axes, extremes, exact and near unit norm.
    push_vec('0, '0, '0);
    push_vec(24'h010000, '0, '0);
    push_vec('0, 24'hff0000, '0);
    push_vec('0, '0, 24'h010000);
    push_vec(24'h7fffff, 24'h7fffff, 24'h7fffff);
    push_vec(24'h800000, 24'h800000, 24'h800000);
    push_vec(24'h800000, '0, '0);
    push_vec(24'h7fffff, '0, 24'h800000);
    push_vec(24'd1, '0, '0);
    push_vec(24'hffffff, 24'hffffff, 24'hffffff);
    push_vec(24'h00ffff, '0, '0);
    push_vec(24'h010001, '0, '0);
    push_vec(24'h009d8a, 24'h009d8a, 24'h009d8a);
    push_vec(24'h555555, 24'haaaaaa, 24'h123456);
    drain_pipeline();
    for (int phase = 0; phase < 5; phase++) begin
      write_tolerance(tol_set[phase]);
      for (int n = 0; n < 230; n++) push_vec(rand_comp(), rand_comp(), rand_comp());
      if (phase == 1) begin
        hold_request = 1;
        wait (hold_cycles != 0);
        hold_request = 0;
      end
      if (phase == 2) begin
        while (pending_vecs.size() > 115) @(posedge clk);
        // Sender pauses here until every result has come back.
        send_pause = 1;
        while (expected_results.size() != 0 || in_valid) @(posedge clk);
        send_pause = 0;
      end
      drain_pipeline();
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
